// ----- src/spt_pkg.sv -----
// ----------------------------------------------------------------------------
// spt_pkg
// types, constants and the cos/sin table builder for the sketch tessellator
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

  localparam int MaxSegments = 63;
  localparam int SegW        = 6;
  localparam int AngW        = 5;
  localparam int TrigDepth   = 2048;
  localparam int PaddrW      = 5;

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  typedef enum logic [1:0] {
    REG_ORIGIN   = 2'd0,
    REG_AXIS_U   = 2'd1,
    REG_AXIS_V   = 2'd2,
    REG_SEGMENTS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               op;
    logic signed [15:0] first_u;
    logic signed [15:0] first_v;
    logic signed [15:0] second_u;
    logic signed [15:0] second_v;
    logic        [14:0] radius;
  } prim_t;

  typedef struct packed {
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [1:0]         quad;
    logic               swap;
    logic [SegW-1:0]    seg;
    logic [AngW-1:0]    ang;
    logic [14:0]        radius;
    logic signed [15:0] pt_u;
    logic signed [15:0] pt_v;
  } seq_pt_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic signed [17:0] u;
    logic signed [17:0] v;
  } plane_pt_t;

  typedef logic [29:0] trig_rom_t [0:TrigDepth-1];

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], a[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // {cos, sin} of r/n of a quarter turn, Q1.14, first octant form
  function automatic logic [29:0] trig_entry(input int n, input int r);
    logic [63:0] x, x2, tc, ts, sc, ss, cc, cs;
    logic [63:0] dc, ds;
    if (n == 0) begin
      return '0;
    end
    x  = udiv(HalfPiQ30 * 64'(r) + 64'(n / 2), 64'(n));
    x2 = (x * x) >> 30;
    sc = OneQ30;
    tc = OneQ30;
    ss = x;
    ts = x;
    for (int k = 1; k <= 7; k++) begin
      dc = 64'((2 * k - 1) * (2 * k));
      ds = 64'((2 * k) * (2 * k + 1));
      tc = udiv((tc * x2) >> 30, dc);
      ts = udiv((ts * x2) >> 30, ds);
      if ((k % 2) == 1) begin
        sc = sc - tc;
        ss = ss - ts;
      end else begin
        sc = sc + tc;
        ss = ss + ts;
      end
    end
    cc = (sc + 64'd32768) >> 16;
    cs = (ss + 64'd32768) >> 16;
    return {cc[14:0], cs[14:0]};
  endfunction

  function automatic trig_rom_t build_trig_rom();
    trig_rom_t rom;
    for (int n = 0; n < (1 << SegW); n++) begin
      for (int r = 0; r < (1 << AngW); r++) begin
        rom[n * (1 << AngW) + r] = trig_entry(n, r);
      end
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// ----- src/spt_seq.sv -----
// ----------------------------------------------------------------------------
// spt_seq
// holds one primitive and steps through its points, one per cycle while advance is high
// ----------------------------------------------------------------------------
`default_nettype none

module spt_seq import spt_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            prim_valid,
  output logic                 prim_stall,
  input  wire prim_t           prim,
  input  wire logic [SegW-1:0] segments,
  input  wire logic            advance,
  output seq_pt_t              pt
);

  logic            busy;
  prim_t           item;
  logic [SegW-1:0] n;
  logic [SegW-1:0] idx;
  logic [1:0]      q;
  logic [SegW-1:0] r;

  logic            accept;
  logic            last_now;
  logic            swap;
  logic [SegW-1:0] r_fold;
  logic [SegW:0]   rr;
  logic [1:0]      qq;
  seq_pt_t         pt_next;

  assign prim_stall = busy;
  assign accept     = prim_valid && !busy;
  assign last_now   = item.op ? (idx == n) : (idx[0] == 1'b1);
  assign swap       = ({r, 1'b0} > {1'b0, n});
  assign r_fold     = swap ? (n - r) : r;

  always_comb begin
    rr = {1'b0, r} + (SegW+1)'(4);
    qq = q;
    for (int k = 0; k < 4; k++) begin
      if (rr >= {1'b0, n}) begin
        rr = rr - {1'b0, n};
        qq = qq + 2'd1;
      end
    end
  end

  always_comb begin
    pt_next.valid  = busy;
    pt_next.last   = last_now;
    pt_next.quad   = q;
    pt_next.swap   = swap;
    pt_next.seg    = n;
    pt_next.ang    = r_fold[AngW-1:0];
    pt_next.radius = item.op ? item.radius : 15'd0;
    pt_next.pt_u   = (!item.op && idx[0]) ? item.second_u : item.first_u;
    pt_next.pt_v   = (!item.op && idx[0]) ? item.second_v : item.first_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pt.valid <= 1'b0;
    end else begin
      if (advance) begin
        pt <= pt_next;
      end
      if (accept) begin
        busy <= 1'b1;
        item <= prim;
        n    <= (segments == '0) ? SegW'(1) : segments;
        idx  <= '0;
        q    <= '0;
        r    <= '0;
      end else if (busy && advance) begin
        if (last_now) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + SegW'(1);
          q   <= qq;
          r   <= rr[SegW-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/spt_trig.sv -----
// ----------------------------------------------------------------------------
// spt_trig
// table lookup, quadrant fix-up, radius scaling and plane point sum
// ----------------------------------------------------------------------------
`default_nettype none

module spt_trig import spt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire seq_pt_t pt,
  output plane_pt_t    plane
);

  localparam trig_rom_t TRIG_ROM = build_trig_rom();

  // stage a
  seq_pt_t     a_pt;
  logic [29:0] a_rom;

  // stage b
  logic               b_valid;
  logic               b_last;
  logic signed [15:0] b_pu;
  logic signed [15:0] b_pv;
  logic signed [31:0] b_pc;
  logic signed [31:0] b_ps;

  logic signed [15:0] cc;
  logic signed [15:0] cs;
  logic signed [15:0] c;
  logic signed [15:0] s;
  logic signed [31:0] rc;
  logic signed [31:0] rs;

  // upper half of a quadrant uses the mirrored octant
  assign cc = a_pt.swap ? 16'(a_rom[14:0]) : 16'(a_rom[29:15]);
  assign cs = a_pt.swap ? 16'(a_rom[29:15]) : 16'(a_rom[14:0]);

  always_comb begin
    case (a_pt.quad)
      2'd0: begin
        c = cc;
        s = cs;
      end
      2'd1: begin
        c = -cs;
        s = cc;
      end
      2'd2: begin
        c = -cc;
        s = -cs;
      end
      default: begin
        c = cs;
        s = -cc;
      end
    endcase
  end

  assign rc = b_pc + 32'sd8192;
  assign rs = b_ps + 32'sd8192;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_pt.valid  <= 1'b0;
      b_valid     <= 1'b0;
      plane.valid <= 1'b0;
    end else if (advance) begin
      a_pt  <= pt;
      a_rom <= TRIG_ROM[{pt.seg, pt.ang}];

      b_valid <= a_pt.valid;
      b_last  <= a_pt.last;
      b_pu    <= a_pt.pt_u;
      b_pv    <= a_pt.pt_v;
      b_pc    <= $signed({1'b0, a_pt.radius}) * c;
      b_ps    <= $signed({1'b0, a_pt.radius}) * s;

      plane.valid <= b_valid;
      plane.last  <= b_last;
      plane.u     <= 18'(b_pu) + 18'(rc >>> 14);
      plane.v     <= 18'(b_pv) + 18'(rs >>> 14);
    end
  end

endmodule

`default_nettype wire

// ----- src/spt_map.sv -----
// ----------------------------------------------------------------------------
// spt_map
// maps a plane point to world space through the plane origin and axes
// ----------------------------------------------------------------------------
`default_nettype none

module spt_map import spt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [47:0] origin,
  input  wire logic [47:0] axis_u,
  input  wire logic [47:0] axis_v,
  input  wire plane_pt_t   plane,
  output logic             point_valid,
  output point_t           point
);

  logic               d_valid;
  logic               d_last;
  logic signed [33:0] d_mu [3];
  logic signed [33:0] d_mv [3];
  logic signed [37:0] acc  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc[a] = $signed({{8{origin[16*a+15]}}, origin[16*a +: 16], 14'd0})
             + 38'(d_mu[a]) + 38'(d_mv[a]) + 38'sd8192;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid     <= 1'b0;
      point_valid <= 1'b0;
    end else if (advance) begin
      d_valid <= plane.valid;
      d_last  <= plane.last;
      for (int a = 0; a < 3; a++) begin
        d_mu[a] <= $signed(axis_u[16*a +: 16]) * plane.u;
        d_mv[a] <= $signed(axis_v[16*a +: 16]) * plane.v;
      end
      point_valid      <= d_valid;
      point.world_x    <= acc[0][37:14];
      point.world_y    <= acc[1][37:14];
      point.world_z    <= acc[2][37:14];
      point.last_point <= d_last;
    end
  end

endmodule

`default_nettype wire

// ----- src/sketch_primitive_tessellator.sv -----
// path: a point goes through item, pt, stage a, stage b, plane, d and point
// throughput: one point per cycle unless point_stall holds; a line is 2 points,
// a circle segments+1 (2 at zero); the point sequencer holds one primitive at a time
// reset: synchronous, clears all valid bits and the sequencer, loads the
// plane registers with origin 0, u = x axis, v = y axis and 32 segments
// ----------------------------------------------------------------------------
// sketch_primitive_tessellator
// turns line and circle words into world space point words
// ----------------------------------------------------------------------------
`default_nettype none

module sketch_primitive_tessellator import spt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  wire logic              prim_valid,
  output logic                   prim_stall,
  input  wire prim_t             prim,
  output logic                   point_valid,
  input  wire logic              point_stall,
  output point_t                 point
);

  logic [47:0]     plane_origin_xyz;
  logic [47:0]     plane_axis_u_xyz;
  logic [47:0]     plane_axis_v_xyz;
  logic [SegW-1:0] circle_segments;

  logic      advance;
  logic      wr;
  reg_idx_t  widx;
  seq_pt_t   pt;
  plane_pt_t plane;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign widx    = reg_idx_t'(paddr[4:3]);
  assign advance = !(point_valid && point_stall);

  always_comb begin
    case (widx)
      REG_ORIGIN:   prdata = {16'd0, plane_origin_xyz};
      REG_AXIS_U:   prdata = {16'd0, plane_axis_u_xyz};
      REG_AXIS_V:   prdata = {16'd0, plane_axis_v_xyz};
      REG_SEGMENTS: prdata = {58'd0, circle_segments};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_origin_xyz <= 48'd0;
      plane_axis_u_xyz <= 48'd16384;
      plane_axis_v_xyz <= 48'd1073741824;
      circle_segments  <= SegW'(32);
    end else if (wr) begin
      case (widx)
        REG_ORIGIN:   plane_origin_xyz <= pwdata[47:0];
        REG_AXIS_U:   plane_axis_u_xyz <= pwdata[47:0];
        REG_AXIS_V:   plane_axis_v_xyz <= pwdata[47:0];
        REG_SEGMENTS: circle_segments  <= pwdata[SegW-1:0];
        default:      circle_segments  <= circle_segments;
      endcase
    end
  end

  spt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .prim_valid (prim_valid),
    .prim_stall (prim_stall),
    .prim       (prim),
    .segments   (circle_segments),
    .advance    (advance),
    .pt         (pt)
  );

  spt_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pt      (pt),
    .plane   (plane)
  );

  spt_map u_map (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .origin      (plane_origin_xyz),
    .axis_u      (plane_axis_u_xyz),
    .axis_v      (plane_axis_v_xyz),
    .plane       (plane),
    .point_valid (point_valid),
    .point       (point)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// sketch_primitive_tessellator testbench
// drives line and circle words under several plane set-ups and flow-control
// mixes, predicts each world point word and checks the output in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spt_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam longint unsigned HalfPiQ30L = 64'd1686629713;
  localparam longint unsigned OneQ30L    = 64'd1073741824;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;
  logic              prim_valid = 1'b0;
  logic              prim_stall;
  prim_t             prim = '0;
  logic              point_valid;
  logic              point_stall = 1'b0;
  point_t            point;

  logic [47:0] origin_q;
  logic [47:0] axis_u_q;
  logic [47:0] axis_v_q;
  logic [5:0]  segments_q;

  point_t pending_points[$];
  bit     failed = 1'b0;
  int     cycles = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;

  sketch_primitive_tessellator DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .prim_valid(prim_valid), .prim_stall(prim_stall), .prim(prim),
    .point_valid(point_valid), .point_stall(point_stall), .point(point)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("sketch_primitive_tessellator regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    point_stall <= ($urandom_range(99) < stall_pct);
  end

  // cos and sin of i/n of a turn, Q1.14
  task automatic unit_circle(input int i, input int n, output longint c, output longint s);
    int unsigned q, r;
    bit swap;
    longint unsigned x, x2, tc, ts, sc, ss;
    longint cc, cs, t;
    q = (4 * i) / n;
    r = 4 * i - q * n;
    swap = 1'b0;
    if (2 * r > n) begin
      r = n - r;
      swap = 1'b1;
    end
    x  = (HalfPiQ30L * r + n / 2) / n;
    x2 = (x * x) >> 30;
    sc = OneQ30L;
    tc = OneQ30L;
    ss = x;
    ts = x;
    for (int k = 1; k <= 7; k++) begin
      tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
      ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sc -= tc;
        ss -= ts;
      end else begin
        sc += tc;
        ss += ts;
      end
    end
    cc = longint'((sc + 32768) >> 16);
    cs = longint'((ss + 32768) >> 16);
    if (swap) begin
      t = cc;
      cc = cs;
      cs = t;
    end
    case (q % 4)
      0: begin c = cc;  s = cs;  end
      1: begin c = -cs; s = cc;  end
      2: begin c = -cc; s = -cs; end
      default: begin c = cs; s = -cc; end
    endcase
  endtask

  function automatic logic [23:0] world_coord(input int a, input longint u, input longint v);
    longint o, pu, pv, acc;
    o   = longint'($signed(origin_q[16*a +: 16]));
    pu  = longint'($signed(axis_u_q[16*a +: 16]));
    pv  = longint'($signed(axis_v_q[16*a +: 16]));
    acc = (o * 16384 + pu * u + pv * v + 8192) >>> 14;
    if (acc > 8388607) acc = 8388607;
    if (acc < -8388608) acc = -8388608;
    return acc[23:0];
  endfunction

  function automatic void queue_point(input longint u, input longint v, input bit last);
    point_t w;
    w.world_x    = world_coord(0, u, v);
    w.world_y    = world_coord(1, u, v);
    w.world_z    = world_coord(2, u, v);
    w.last_point = last;
    pending_points = {pending_points, w};
  endfunction

  task automatic tessellate(input prim_t p);
    int n;
    longint r, c, s, cu, cv;
    if (p.op == 1'b0) begin
      queue_point(longint'(p.first_u), longint'(p.first_v), 1'b0);
      queue_point(longint'(p.second_u), longint'(p.second_v), 1'b1);
    end else begin
      r = longint'(p.radius);
      n = (segments_q == 0) ? 1 : int'(segments_q);
      if (n > MaxSegments) n = MaxSegments;
      for (int i = 0; i <= n; i++) begin
        unit_circle(i, n, c, s);
        cu = longint'(p.first_u) + ((r * c + 8192) >>> 14);
        cv = longint'(p.first_v) + ((r * s + 8192) >>> 14);
        queue_point(cu, cv, i == n);
      end
    end
  endtask

  always @(posedge clk) begin
    point_t want;
    if (!rst && point_valid && !point_stall) begin
      if (pending_points.size() == 0) begin
        $error("point word with none expected");
        failed = 1'b1;
      end else begin
        want = pending_points.pop_front();
        if (point.world_x !== want.world_x) begin
          $error("world_x expected %0h got %0h", want.world_x, point.world_x);
          failed = 1'b1;
        end
        if (point.world_y !== want.world_y) begin
          $error("world_y expected %0h got %0h", want.world_y, point.world_y);
          failed = 1'b1;
        end
        if (point.world_z !== want.world_z) begin
          $error("world_z expected %0h got %0h", want.world_z, point.world_z);
          failed = 1'b1;
        end
        if (point.last_point !== want.last_point) begin
          $error("last_point expected %0b got %0b", want.last_point, point.last_point);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_prim(input prim_t p);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      prim_valid = 1'b0;
      @(negedge clk);
    end
    prim_valid = 1'b1;
    prim = p;
    do @(posedge clk); while (prim_stall);
    tessellate(p);
  endtask

  task automatic drain();
    @(negedge clk);
    prim_valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [47:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = PaddrW'(8 * int'(idx));
    pwdata = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ORIGIN:   origin_q = value;
      REG_AXIS_U:   axis_u_q = value;
      REG_AXIS_V:   axis_v_q = value;
      REG_SEGMENTS: segments_q = value[5:0];
      default:      ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic prim_t make_line(input logic [15:0] au, av, bu, bv);
    prim_t p;
    p = '0;
    p.op = 1'b0;
    p.first_u = au;
    p.first_v = av;
    p.second_u = bu;
    p.second_v = bv;
    p.radius = 15'($urandom);
    return p;
  endfunction

  function automatic prim_t make_circle(input logic [15:0] cu, cv, input logic [14:0] rad);
    prim_t p;
    p = '0;
    p.op = 1'b1;
    p.first_u = cu;
    p.first_v = cv;
    p.second_u = 16'($urandom);
    p.second_v = 16'($urandom);
    p.radius = rad;
    return p;
  endfunction

  function automatic prim_t random_prim();
    prim_t p;
    p = prim_t'(80'({$urandom, $urandom, $urandom}));
    if ($urandom_range(3) == 0) p.radius = 15'($urandom_range(2048));
    return p;
  endfunction

  task automatic test_lines();
    send_prim(make_line(16'h0000, 16'h0000, 16'h0100, 16'h0100));
    send_prim(make_line(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
    send_prim(make_line(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001));
    drain();
  endtask

  task automatic test_circles();
    int seg_list[4] = '{1, 2, 3, 63};
    send_prim(make_circle(16'h0000, 16'h0000, 15'd0));
    send_prim(make_circle(16'h0000, 16'h0000, 15'h7FFF));
    send_prim(make_circle(16'h7FFF, 16'h8000, 15'h7FFF));
    drain();
    write_reg(REG_SEGMENTS, 48'd0);
    send_prim(make_circle(16'h0100, 16'hFF00, 15'h0400));
    drain();
    foreach (seg_list[k]) begin
      write_reg(REG_SEGMENTS, 48'(seg_list[k]));
      send_prim(make_circle(16'h1234, 16'hEDCB, 15'h2A55));
      drain();
    end
  endtask

  task automatic test_saturation();
    write_reg(REG_ORIGIN, 48'h8000_7FFF_7FFF);
    write_reg(REG_AXIS_U, 48'h7FFF_8000_7FFF);
    write_reg(REG_AXIS_V, 48'h8000_7FFF_7FFF);
    write_reg(REG_SEGMENTS, 48'd5);
    send_prim(make_line(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    send_prim(make_circle(16'h8000, 16'h7FFF, 15'h7FFF));
    drain();
  endtask

  task automatic test_random(input int idle, input int stall, input int count);
    write_reg(REG_ORIGIN, ($urandom_range(1)) ? 48'({$urandom, $urandom}) : 48'd0);
    write_reg(REG_AXIS_U, ($urandom_range(2) == 0) ? 48'd16384 : 48'({$urandom, $urandom}));
    write_reg(REG_AXIS_V, ($urandom_range(2) == 0) ? 48'h4000_0000 : 48'({$urandom, $urandom}));
    write_reg(REG_SEGMENTS, ($urandom_range(9) == 0) ? 48'd63 : 48'($urandom_range(12)));
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_prim(random_prim());
    drain();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    origin_q = '0;
    axis_u_q = 48'd16384;
    axis_v_q = 48'h4000_0000;
    segments_q = 6'd32;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_lines();
    send_prim(make_circle(16'h0000, 16'h0000, 15'h0100));
    drain();
    test_circles();
    test_saturation();
    test_random(0, 0, 55);
    test_random(64, 0, 55);
    test_random(0, 64, 55);
    test_random(8, 8, 55);
    test_random(0, 0, 10);
    if (!failed) begin
      $display("sketch_primitive_tessellator regression: pass");
    end else begin
      $display("sketch_primitive_tessellator regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/spt_pkg.sv
src/spt_seq.sv
src/spt_trig.sv
src/spt_map.sv
src/sketch_primitive_tessellator.sv
dv/tb.sv
